// File: hdl/bmp_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the binomial coefficient modulo prime core.
// -----------------------------------------------------------------------------
package bmp_pkg;

	// field widths
	localparam int ARG_W   = 21;
	localparam int MOD_W   = 31;
	localparam int RECIP_W = 64;

	// arguments above this bound are saturated to it
	localparam logic [MOD_W-1:0] MAX_TOTAL = 31'd1048576;
	// modulus after reset
	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	// operand and destination selection of one modular multiplication
	typedef enum logic [2:0] {
		MM_FACT,
		MM_PACC,
		MM_PSQR,
		MM_FIN1,
		MM_FIN2
	} mm_op_t;

	// phases of the barrett multiplier
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LL,
		PH_LH,
		PH_HL,
		PH_HH,
		PH_QSUM,
		PH_QP,
		PH_SUB,
		PH_FIX
	} mm_phase_t;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RECIP,
		ST_FACT_INIT,
		ST_FACT_MUL,
		ST_FACT_WAIT,
		ST_POW_INIT,
		ST_POW_TEST,
		ST_POW_MUL,
		ST_POW_MWAIT,
		ST_POW_SQR,
		ST_POW_SWAIT,
		ST_FIN1,
		ST_FIN1_WAIT,
		ST_FIN2,
		ST_FIN2_WAIT,
		ST_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic   load_in;
		logic   zero_res;
		logic   recip_start;
		logic   fact_init;
		logic   i_inc;
		logic   pow_init;
		logic   pow_sel_d;
		logic   save_inv;
		logic   expo_shift;
		logic   mm_start;
		mm_op_t mm_op;
		logic   load_out;
	} bmp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stop_early;
		logic n_small;
		logic i_last;
		logic expo_zero;
		logic expo_lsb;
		logic recip_done;
		logic mm_done;
		logic out_free;
	} bmp_status_t;

endpackage

// File: hdl/binomial_mod_prime_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// binomial_mod_prime_core
// C(total, chosen) modulo a programmable modulus: factorials by repeated
// modular multiplication, inverses by fermat exponentiation.
// -----------------------------------------------------------------------------
//  channel  signals                          transfer when
//  -------  -------------------------------  ----------------------------
//  in       in_valid in_ready total chosen    in_valid & in_ready
//  out      out_valid out_ready binom_value   out_valid & out_ready
//           chosen_exceeds
//  cfg      cfg_wr_en cfg_wr_data             cfg_wr_en
//
//  one item at a time; an item runs the 64 step reciprocal divider, then one
//  modular multiplication on the barrett unit per factorial factor from 2 to
//  total, at most 124 exponent multiplications and two final products.
//  chosen above total, or a modulus below 2, gives a zero result without the
//  divider or the multiplier. a finished result waits in the output register;
//  the next item is taken once it has been moved there. reset clears control
//  and reloads the modulus.
// -----------------------------------------------------------------------------
module binomial_mod_prime_core import bmp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [MOD_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ARG_W-1:0] total,
	input  logic [ARG_W-1:0] chosen,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [MOD_W-1:0] binom_value,
	output logic             chosen_exceeds
);

	bmp_cmd_t    cmd;
	bmp_status_t status;

	bmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bmp_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.total          (total),
		.chosen         (chosen),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.binom_value    (binom_value),
		.chosen_exceeds (chosen_exceeds)
	);

endmodule

// File: hdl/bmp_recip.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bmp_recip
// Restoring divider that forms floor(2^64 / p), one quotient bit per cycle.
// -----------------------------------------------------------------------------
module bmp_recip import bmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MOD_W-1:0]   divisor,
	output logic               done,
	output logic [RECIP_W-1:0] recip
);

	localparam int CNT_W = $clog2(RECIP_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RECIP_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MOD_W-1:0]   rem_q;
	logic [RECIP_W-1:0] quo_q;

	logic [MOD_W:0] trial;
	logic [MOD_W:0] trial_sub;
	logic           fits;

	// one restoring step: shift in a zero dividend bit
	always_comb begin
		trial     = {rem_q, 1'b0};
		trial_sub = trial - {1'b0, divisor};
		fits      = (trial >= {1'b0, divisor});
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient, the leading dividend bit is preloaded
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= MOD_W'(1);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[MOD_W-1:0] : trial[MOD_W-1:0];
			quo_q <= {quo_q[RECIP_W-2:0], fits};
		end
	end

	assign done  = done_q;
	assign recip = quo_q;

endmodule

// File: hdl/bmp_mulmod.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bmp_mulmod
// Modular multiplier: a*b mod p by barrett reduction on one shared
// 32x32 multiplier.
// -----------------------------------------------------------------------------
module bmp_mulmod import bmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MOD_W-1:0]   op_a,
	input  logic [MOD_W-1:0]   op_b,
	input  logic [MOD_W-1:0]   modulus,
	input  logic [RECIP_W-1:0] recip,
	output logic               done,
	output logic [MOD_W-1:0]   result
);

	localparam int HALF_W = RECIP_W / 2;
	localparam int ACC_W  = RECIP_W + 2;

	mm_phase_t phase_q;
	mm_phase_t phase_d;
	logic      done_q;

	logic [RECIP_W-1:0] prod_q;
	logic [RECIP_W-1:0] x_q;
	logic [ACC_W-1:0]   acc_q;
	logic [HALF_W-1:0]  diff_q;
	logic [MOD_W-1:0]   res_q;

	logic [HALF_W-1:0]  mul_x;
	logic [HALF_W-1:0]  mul_y;
	logic [RECIP_W-1:0] mul_p;
	logic [HALF_W-1:0]  mod_ext;
	logic [HALF_W-1:0]  diff_sub;
	logic [MOD_W-1:0]   res_d;

	assign mod_ext = {1'b0, modulus};

	// phase sequence
	always_comb begin
		case (phase_q)
			PH_IDLE: phase_d = start ? PH_LL : PH_IDLE;
			PH_LL:   phase_d = PH_LH;
			PH_LH:   phase_d = PH_HL;
			PH_HL:   phase_d = PH_HH;
			PH_HH:   phase_d = PH_QSUM;
			PH_QSUM: phase_d = PH_QP;
			PH_QP:   phase_d = PH_SUB;
			PH_SUB:  phase_d = PH_FIX;
			PH_FIX:  phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	// shared multiplier input selection
	always_comb begin
		case (phase_q)
			PH_IDLE: begin
				mul_x = {1'b0, op_a};
				mul_y = {1'b0, op_b};
			end
			PH_LL: begin
				mul_x = prod_q[HALF_W-1:0];
				mul_y = recip[HALF_W-1:0];
			end
			PH_LH: begin
				mul_x = x_q[HALF_W-1:0];
				mul_y = recip[RECIP_W-1:HALF_W];
			end
			PH_HL: begin
				mul_x = x_q[RECIP_W-1:HALF_W];
				mul_y = recip[HALF_W-1:0];
			end
			PH_HH: begin
				mul_x = x_q[RECIP_W-1:HALF_W];
				mul_y = recip[RECIP_W-1:HALF_W];
			end
			PH_QP: begin
				mul_x = acc_q[HALF_W-1:0];
				mul_y = mod_ext;
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
		mul_p = mul_x * mul_y;
	end

	// final correction, remainder estimate lies below 2p
	always_comb begin
		diff_sub = diff_q - mod_ext;
		res_d    = (diff_q >= mod_ext) ? diff_sub[MOD_W-1:0] : diff_q[MOD_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == PH_FIX);
		end
	end

	// product, quotient estimate and remainder
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (phase_q)
			PH_LL:   x_q <= prod_q;
			PH_LH:   acc_q <= {{(ACC_W-HALF_W){1'b0}}, prod_q[RECIP_W-1:HALF_W]};
			PH_HL:   acc_q <= acc_q + {2'b00, prod_q};
			PH_HH:   acc_q <= acc_q + {2'b00, prod_q};
			PH_QSUM: acc_q <= {{HALF_W{1'b0}}, acc_q[ACC_W-1:HALF_W]} + {2'b00, prod_q};
			PH_SUB:  diff_q <= x_q[HALF_W-1:0] - prod_q[HALF_W-1:0];
			PH_FIX:  res_q <= res_d;
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hdl/bmp_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bmp_datapath
// Argument, factorial, exponentiation and output registers around the
// reciprocal divider and the modular multiplier.
// -----------------------------------------------------------------------------
module bmp_datapath import bmp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [MOD_W-1:0] cfg_wr_data,
	input  logic [ARG_W-1:0] total,
	input  logic [ARG_W-1:0] chosen,
	input  logic             out_ready,
	input  bmp_cmd_t         cmd,
	output bmp_status_t      status,
	output logic             out_valid,
	output logic [MOD_W-1:0] binom_value,
	output logic             chosen_exceeds
);

	localparam int PAD_W = MOD_W - ARG_W;

	logic [MOD_W-1:0] prime_q;
	logic [ARG_W-1:0] n_q;
	logic [ARG_W-1:0] r_q;
	logic [ARG_W-1:0] d_q;
	logic             exceeds_q;
	logic [ARG_W-1:0] i_q;
	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] fr_q;
	logic [MOD_W-1:0] fd_q;
	logic [MOD_W-1:0] base_q;
	logic [MOD_W-1:0] pacc_q;
	logic [MOD_W-1:0] inv_r_q;
	logic [MOD_W-1:0] expo_q;
	logic [MOD_W-1:0] res_q;
	mm_op_t           op_q;
	logic             out_valid_q;
	logic [MOD_W-1:0] out_value_q;
	logic             out_flag_q;

	logic [ARG_W-1:0]   n_sat;
	logic [ARG_W-1:0]   r_sat;
	logic [MOD_W-1:0]   mm_a;
	logic [MOD_W-1:0]   mm_b;
	logic [MOD_W-1:0]   mm_res;
	logic               mm_done;
	logic [RECIP_W-1:0] recip;
	logic               recip_done;

	// saturate the arguments
	always_comb begin
		n_sat = ({{PAD_W{1'b0}}, total} > MAX_TOTAL) ? MAX_TOTAL[ARG_W-1:0] : total;
		r_sat = ({{PAD_W{1'b0}}, chosen} > MAX_TOTAL) ? MAX_TOTAL[ARG_W-1:0] : chosen;
	end

	// multiplier operands, sampled on start
	always_comb begin
		case (cmd.mm_op)
			MM_FACT: begin
				mm_a = acc_q;
				mm_b = {{PAD_W{1'b0}}, i_q};
			end
			MM_PACC: begin
				mm_a = pacc_q;
				mm_b = base_q;
			end
			MM_PSQR: begin
				mm_a = base_q;
				mm_b = base_q;
			end
			MM_FIN1: begin
				mm_a = acc_q;
				mm_b = inv_r_q;
			end
			MM_FIN2: begin
				mm_a = res_q;
				mm_b = pacc_q;
			end
			default: begin
				mm_a = '0;
				mm_b = '0;
			end
		endcase
	end

	bmp_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.recip_start),
		.divisor (prime_q),
		.done    (recip_done),
		.recip   (recip)
	);

	bmp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.modulus (prime_q),
		.recip   (recip),
		.done    (mm_done),
		.result  (mm_res)
	);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= MOD_RESET;
		end else if (cfg_wr_en) begin
			prime_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= res_q;
			out_flag_q  <= exceeds_q;
		end
	end

	// argument capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			n_q       <= n_sat;
			r_q       <= r_sat;
			d_q       <= n_sat - r_sat;
			exceeds_q <= (r_sat > n_sat);
		end
	end

	// factorial loop
	always_ff @(posedge clk) begin
		if (cmd.fact_init) begin
			acc_q <= MOD_W'(1);
			fr_q  <= MOD_W'(1);
			fd_q  <= MOD_W'(1);
			i_q   <= ARG_W'(2);
		end else begin
			if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (mm_done && (op_q == MM_FACT)) begin
				acc_q <= mm_res;
				if (i_q == r_q) begin
					fr_q <= mm_res;
				end
				if (i_q == d_q) begin
					fd_q <= mm_res;
				end
			end
		end
	end

	// exponentiation and final products
	always_ff @(posedge clk) begin
		if (cmd.mm_start) begin
			op_q <= cmd.mm_op;
		end
		if (cmd.pow_init) begin
			base_q <= cmd.pow_sel_d ? fd_q : fr_q;
			pacc_q <= MOD_W'(1);
			expo_q <= prime_q - MOD_W'(2);
		end else begin
			if (cmd.expo_shift) begin
				expo_q <= expo_q >> 1;
			end
			if (mm_done && (op_q == MM_PACC)) begin
				pacc_q <= mm_res;
			end
			if (mm_done && (op_q == MM_PSQR)) begin
				base_q <= mm_res;
			end
		end
		if (cmd.save_inv) begin
			inv_r_q <= pacc_q;
		end
		if (cmd.zero_res) begin
			res_q <= '0;
		end else if (mm_done && ((op_q == MM_FIN1) || (op_q == MM_FIN2))) begin
			res_q <= mm_res;
		end
	end

	// status to the controller
	always_comb begin
		status.stop_early = exceeds_q || (prime_q < MOD_W'(2));
		status.n_small    = (n_q < ARG_W'(2));
		status.i_last     = (i_q == n_q);
		status.expo_zero  = (expo_q == '0);
		status.expo_lsb   = expo_q[0];
		status.recip_done = recip_done;
		status.mm_done    = mm_done;
		status.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign binom_value    = out_value_q;
	assign chosen_exceeds = out_flag_q;

endmodule

// File: hdl/bmp_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bmp_ctrl
// Controller: sequences reciprocal, factorial loop, the two fermat
// exponentiations and the final products.
// -----------------------------------------------------------------------------
module bmp_ctrl import bmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bmp_status_t status,
	output bmp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        second_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_CHECK;
			ST_CHECK:     state_d = status.stop_early ? ST_DONE : ST_RECIP;
			ST_RECIP:     if (status.recip_done) state_d = ST_FACT_INIT;
			ST_FACT_INIT: state_d = status.n_small ? ST_POW_INIT : ST_FACT_MUL;
			ST_FACT_MUL:  state_d = ST_FACT_WAIT;
			ST_FACT_WAIT: begin
				if (status.mm_done) begin
					state_d = status.i_last ? ST_POW_INIT : ST_FACT_MUL;
				end
			end
			ST_POW_INIT:  state_d = ST_POW_TEST;
			ST_POW_TEST: begin
				if (status.expo_zero) begin
					state_d = second_q ? ST_FIN1 : ST_POW_INIT;
				end else begin
					state_d = status.expo_lsb ? ST_POW_MUL : ST_POW_SQR;
				end
			end
			ST_POW_MUL:   state_d = ST_POW_MWAIT;
			ST_POW_MWAIT: if (status.mm_done) state_d = ST_POW_SQR;
			ST_POW_SQR:   state_d = ST_POW_SWAIT;
			ST_POW_SWAIT: if (status.mm_done) state_d = ST_POW_TEST;
			ST_FIN1:      state_d = ST_FIN1_WAIT;
			ST_FIN1_WAIT: if (status.mm_done) state_d = ST_FIN2;
			ST_FIN2:      state_d = ST_FIN2_WAIT;
			ST_FIN2_WAIT: if (status.mm_done) state_d = ST_DONE;
			ST_DONE:      if (status.out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		cmd.mm_op = MM_FACT;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_CHECK: begin
				cmd.zero_res    = status.stop_early;
				cmd.recip_start = !status.stop_early;
			end
			ST_FACT_INIT: cmd.fact_init = 1'b1;
			ST_FACT_MUL: begin
				cmd.mm_start = 1'b1;
				cmd.mm_op    = MM_FACT;
			end
			ST_FACT_WAIT: cmd.i_inc = status.mm_done && !status.i_last;
			ST_POW_INIT: begin
				cmd.pow_init  = 1'b1;
				cmd.pow_sel_d = second_q;
			end
			ST_POW_TEST: cmd.save_inv = status.expo_zero && !second_q;
			ST_POW_MUL: begin
				cmd.mm_start = 1'b1;
				cmd.mm_op    = MM_PACC;
			end
			ST_POW_SQR: begin
				cmd.mm_start = 1'b1;
				cmd.mm_op    = MM_PSQR;
			end
			ST_POW_SWAIT: cmd.expo_shift = status.mm_done;
			ST_FIN1: begin
				cmd.mm_start = 1'b1;
				cmd.mm_op    = MM_FIN1;
			end
			ST_FIN2: begin
				cmd.mm_start = 1'b1;
				cmd.mm_op    = MM_FIN2;
			end
			ST_DONE: cmd.load_out = status.out_free;
			default: ;
		endcase
	end

	// state and exponentiation pass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				second_q <= 1'b0;
			end else if ((state_q == ST_POW_TEST) && status.expo_zero) begin
				second_q <= 1'b1;
			end
		end
	end

endmodule
